// File: hdl/qrv_pkg.sv
// Shared types, constants and helpers for the quaternion multiply / rotate core.
// No dependencies; every other file in hdl/ depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package qrv_pkg;

  localparam int unsigned COMP_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IN_DATA_W     = 8 * COMP_W;
  localparam int unsigned OUT_DATA_W    = 4 * COMP_W;
  localparam int unsigned NUM_TERMS     = 16;

  // Component order inside a quaternion: w, x, y, z from the lowest bits up.
  typedef logic [3:0][COMP_W-1:0] quat_t;

  localparam logic [1:0] IW = 2'd0;
  localparam logic [1:0] IX = 2'd1;
  localparam logic [1:0] IY = 2'd2;
  localparam logic [1:0] IZ = 2'd3;

  // Opcode carried in tuser.
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_ROT = 1'b1;

  // Hamilton product term map, entry = 4*component + term.
  localparam logic [0:NUM_TERMS-1][1:0] P_SEL = '{
    IW, IX, IY, IZ,
    IW, IX, IY, IZ,
    IW, IY, IZ, IX,
    IW, IZ, IX, IY
  };
  localparam logic [0:NUM_TERMS-1][1:0] Q_SEL = '{
    IW, IX, IY, IZ,
    IX, IW, IZ, IY,
    IY, IW, IX, IZ,
    IZ, IW, IY, IX
  };
  localparam logic [0:NUM_TERMS-1] T_NEG = 16'b0111_0001_0001_0001;

  localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};

  // Negate with saturation: the most negative value maps to the most positive.
  function automatic logic [COMP_W-1:0] sat_neg(input logic [COMP_W-1:0] v);
    logic [COMP_W-1:0] r;
    if (v == COMP_MIN) begin
      r = COMP_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/qrv_qmul.sv
// Four-stage pipelined Hamilton product r = p*q in signed fixed point.
// Depends on qrv_pkg. Stages: 16 products, pair sums, final sum, shift/saturate.
`timescale 1ns / 1ps
`default_nettype none

module qrv_qmul #(
  parameter int unsigned FRAC_BITS = qrv_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  qrv_pkg::quat_t      p_i,
  input  qrv_pkg::quat_t      q_i,
  input  wire  [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output qrv_pkg::quat_t      r_o,
  output logic [SIDE_W-1:0]   side_o
);
  import qrv_pkg::*;

  localparam int unsigned PROD_W = 2 * COMP_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned NSTG   = 4;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   en;
  logic [SIDE_W-1:0] side_q [NSTG];

  logic signed [PROD_W-1:0] prod_d [NUM_TERMS];
  logic signed [PROD_W-1:0] prod_q [NUM_TERMS];
  logic signed [PAIR_W-1:0] pair_d [8];
  logic signed [PAIR_W-1:0] pair_q [8];
  logic signed [SUM_W-1:0]  sum_d  [4];
  logic signed [SUM_W-1:0]  sum_q  [4];
  quat_t                    r_d;
  quat_t                    r_q;

  // A stage takes new data when empty or when its content moves on.
  assign en[NSTG] = ready_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] qa;
    for (int i = 0; i < NUM_TERMS; i++) begin
      pa        = PROD_W'($signed(p_i[P_SEL[i]]));
      qa        = PROD_W'($signed(q_i[Q_SEL[i]]));
      prod_d[i] = pa * qa;
    end
  end

  always_comb begin
    logic signed [PAIR_W-1:0] t0;
    logic signed [PAIR_W-1:0] t1;
    for (int j = 0; j < 8; j++) begin
      t0 = PAIR_W'(prod_q[2*j]);
      t1 = PAIR_W'(prod_q[2*j+1]);
      if (T_NEG[2*j]) begin
        t0 = -t0;
      end
      if (T_NEG[2*j+1]) begin
        t1 = -t1;
      end
      pair_d[j] = t0 + t1;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = SUM_W'(pair_q[2*c]) + SUM_W'(pair_q[2*c+1]);
    end
  end

  // Floor shift, then clamp when the upper bits are not a pure sign extension.
  always_comb begin
    logic signed [SUM_W-1:0]    sh;
    logic [SUM_W-COMP_W:0]      hi;
    for (int c = 0; c < 4; c++) begin
      sh = sum_q[c] >>> FRAC_BITS;
      hi = sh[SUM_W-1:COMP_W-1];
      if ((&hi) || !(|hi)) begin
        r_d[c] = sh[COMP_W-1:0];
      end else if (sh[SUM_W-1]) begin
        r_d[c] = COMP_MIN;
      end else begin
        r_d[c] = COMP_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    if (en[1]) begin
      for (int j = 0; j < 8; j++) begin
        pair_q[j] <= pair_d[j];
      end
    end
    if (en[2]) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= sum_d[c];
      end
    end
    if (en[3]) begin
      r_q <= r_d;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign r_o     = r_q;
  assign side_o  = side_q[NSTG-1];

endmodule

`default_nettype wire

// File: hdl/quaternion_rotate_vector_core.sv
// Top level: quaternion multiply (a*b) or vector rotation (a*v*conj(a)).
// Depends on qrv_pkg and qrv_qmul; two product pipes run back to back.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | a_w a_x a_y a_z b_w b_x b_y b_z, 32 b each  | opcode
//  m_axis   | out | r_w r_x r_y r_z, 32 b each                  | -
//
// One transfer per cycle in and out while m_axis_tready_i holds; the path is two 4-stage
// product pipes. A multiply passes through the second pipe against the unit
// quaternion, so both opcodes share one path and stay in order.
// rst_ni clears only the stage valid bits; data registers are not reset.
// A stage holds only while full and blocked downstream, so bubbles are
// squeezed out and input is taken while a result waits if any stage is empty.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_rotate_vector_core #(
  parameter int unsigned FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  wire  [qrv_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // opcode
  input  wire  [0:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // r_w, r_x, r_y, r_z
  output logic [qrv_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import qrv_pkg::*;

  localparam int unsigned SIDE1_W = 1 + $bits(quat_t);

  quat_t a;
  quat_t b;
  quat_t b_in;
  quat_t q2_in;
  quat_t t;
  quat_t q2;
  quat_t r;
  logic  op;
  logic  op1;
  logic  op2;
  logic  t_vld;
  logic  t_rdy;
  logic [COMP_W-1:0] unit_w;

  assign a  = s_axis_tdata_i[4*COMP_W-1:0];
  assign b  = s_axis_tdata_i[8*COMP_W-1:4*COMP_W];
  assign op = s_axis_tuser_i[0];

  assign unit_w = COMP_W'(1) << FRAC_BITS;

  always_comb begin
    b_in = b;
    if (op == OP_ROT) begin
      b_in[IW]  = '0;
      q2_in[IW] = a[IW];
      q2_in[IX] = sat_neg(a[IX]);
      q2_in[IY] = sat_neg(a[IY]);
      q2_in[IZ] = sat_neg(a[IZ]);
    end else begin
      q2_in     = '0;
      q2_in[IW] = unit_w;
    end
  end

  qrv_qmul #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE1_W)
  ) u_pass1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .p_i     (a),
    .q_i     (b_in),
    .side_i  ({op, q2_in}),
    .valid_o (t_vld),
    .ready_i (t_rdy),
    .r_o     (t),
    .side_o  ({op1, q2})
  );

  qrv_qmul #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (1)
  ) u_pass2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_vld),
    .ready_o (t_rdy),
    .p_i     (t),
    .q_i     (q2),
    .side_i  (op1),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .r_o     (r),
    .side_o  (op2)
  );

  assign m_axis_tdata_o = {r[IZ], r[IY], r[IX], (op2 == OP_ROT) ? '0 : r[IW]};

endmodule

`default_nettype wire

// File: hdl/qrv_checker.sv
// Port-level checks for quaternion_rotate_vector_core, attached by bind.
// Depends on qrv_pkg for the data widths.
`timescale 1ns / 1ps
`default_nettype none

module qrv_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid_i,
  input wire                            s_axis_tready_o,
  input wire [qrv_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input wire [0:0]                      s_axis_tuser_i,
  input wire                            m_axis_tvalid_o,
  input wire                            m_axis_tready_i,
  input wire [qrv_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output changed while stalled");

  // Coming out of reset the pipe is empty.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // The pipe can only block input when the output end is blocked.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input blocked with a free output");

  // No output can show up right after reset with nothing sent in.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!rst_ni) && !(s_axis_tvalid_i && s_axis_tready_o)) |=> !m_axis_tvalid_o)
    else $error("result without a transfer");

endmodule

bind quaternion_rotate_vector_core qrv_checker u_qrv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for quaternion_rotate_vector_core: directed rows, then random transfers.
// Expected results come from a local fixed-point predictor or fixed row values; uses qrv_pkg.
`timescale 1ns / 1ps

module tb_top;
  import qrv_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned N_RANDOM = 400;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] CMAX = COMP_MAX;
  localparam logic [31:0] CMIN = COMP_MIN;
  localparam logic signed [66:0] SUM_HI = 67'sh7FFF_FFFF;
  localparam logic signed [66:0] SUM_LO = -67'sh8000_0000;

  typedef struct {
    logic  op;
    quat_t a;
    quat_t b;
    bit    fixed_exp;
    quat_t want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [0:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  quat_t     result_q[$];
  stim_row_t dir_tab[$];
  int        err_cnt = 0;
  bit        tx_idle_en = 1'b1;
  logic      rx_idle_en;
  logic      rx_hold_req;

  quaternion_rotate_vector_core #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- predictor ----------------

  function automatic logic signed [66:0] wide_mul(input logic [31:0] p, input logic [31:0] q);
    logic signed [66:0] ps;
    logic signed [66:0] qs;
    ps = $signed(p);
    qs = $signed(q);
    return ps * qs;
  endfunction

  // floor(sum / 2^FRAC), clipped to 32 bits
  function automatic logic [31:0] shift_sat(input logic signed [66:0] s);
    logic signed [66:0] sh;
    sh = s >>> FRAC;
    if (sh > SUM_HI) begin
      return CMAX;
    end else if (sh < SUM_LO) begin
      return CMIN;
    end
    return sh[31:0];
  endfunction

  function automatic quat_t hamilton_fx(input quat_t p, input quat_t q);
    quat_t r;
    r[IW] = shift_sat(wide_mul(p[IW], q[IW]) - wide_mul(p[IX], q[IX])
                    - wide_mul(p[IY], q[IY]) - wide_mul(p[IZ], q[IZ]));
    r[IX] = shift_sat(wide_mul(p[IW], q[IX]) + wide_mul(p[IX], q[IW])
                    + wide_mul(p[IY], q[IZ]) - wide_mul(p[IZ], q[IY]));
    r[IY] = shift_sat(wide_mul(p[IW], q[IY]) + wide_mul(p[IY], q[IW])
                    + wide_mul(p[IZ], q[IX]) - wide_mul(p[IX], q[IZ]));
    r[IZ] = shift_sat(wide_mul(p[IW], q[IZ]) + wide_mul(p[IZ], q[IW])
                    + wide_mul(p[IX], q[IY]) - wide_mul(p[IY], q[IX]));
    return r;
  endfunction

  function automatic logic [31:0] neg_clip(input logic [31:0] v);
    return (v == CMIN) ? CMAX : -v;
  endfunction

  function automatic quat_t predict_result(input logic op, input quat_t a, input quat_t b);
    quat_t conj;
    quat_t r;
    if (op == OP_ROT) begin
      b[IW] = '0;
      conj[IW] = a[IW];
      conj[IX] = neg_clip(a[IX]);
      conj[IY] = neg_clip(a[IY]);
      conj[IZ] = neg_clip(a[IZ]);
      r = hamilton_fx(hamilton_fx(a, b), conj);
      r[IW] = '0;
    end else begin
      r = hamilton_fx(a, b);
    end
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic quat_t mk_quat(input logic [31:0] w, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z);
    return {z, y, x, w};
  endfunction

  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(2 * 65536) - 65536;   // around unit scale
      4, 5:       v = $urandom();
      6, 7:       v = $urandom_range(1 << 25) - (1 << 24);
      8: begin
        case ($urandom_range(5))
          0:       v = CMAX;
          1:       v = CMIN;
          2:       v = '0;
          3:       v = '1;
          4:       v = ONE;
          default: v = -ONE;
        endcase
      end
      default:    v = $urandom_range(255) - 128;
    endcase
    return v;
  endfunction

  function automatic quat_t rand_quat();
    return mk_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endfunction

  task automatic add_row(input logic op, input quat_t a, input quat_t b,
                         input bit fixed_exp, input quat_t want);
    stim_row_t row;
    row.op = op;
    row.a = a;
    row.b = b;
    row.fixed_exp = fixed_exp;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Holds tvalid until the transfer, then queues what it should produce.
  task automatic send_item(input logic op, input quat_t a, input quat_t b, input quat_t want);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    result_q.push_back(want);
  endtask

  task automatic idle_gap();
    while (tx_idle_en && $urandom_range(99) < 31) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- sender ----------------

  initial begin
    logic  op;
    quat_t a;
    quat_t b;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_MUL;
    rx_idle_en      = 1'b1;
    rx_hold_req     = 1'b0;

    // multiply: zero, identity, saturation, floor of small negatives, basis units
    add_row(OP_MUL, '0, '0, 1, '0);
    add_row(OP_MUL, mk_quat(ONE, 0, 0, 0), mk_quat(CMAX, CMIN, '1, 12345), 1,
            mk_quat(CMAX, CMIN, '1, 12345));
    add_row(OP_MUL, mk_quat(CMAX, 0, 0, 0), mk_quat(CMAX, 0, 0, 0), 1, mk_quat(CMAX, 0, 0, 0));
    add_row(OP_MUL, mk_quat(CMIN, 0, 0, 0), mk_quat(CMIN, 0, 0, 0), 1, mk_quat(CMAX, 0, 0, 0));
    add_row(OP_MUL, mk_quat(CMIN, 0, 0, 0), mk_quat(CMAX, 0, 0, 0), 1, mk_quat(CMIN, 0, 0, 0));
    add_row(OP_MUL, mk_quat('1, 0, 0, 0), mk_quat(1, 0, 0, 0), 1, mk_quat('1, 0, 0, 0));
    add_row(OP_MUL, mk_quat(0, ONE, 0, 0), mk_quat(0, ONE, 0, 0), 1, mk_quat(-ONE, 0, 0, 0));
    add_row(OP_MUL, mk_quat(0, ONE, 0, 0), mk_quat(0, 0, ONE, 0), 1, mk_quat(0, 0, 0, ONE));
    add_row(OP_MUL, {4{CMAX}}, {4{CMAX}}, 0, '0);
    add_row(OP_MUL, {4{CMIN}}, {4{CMIN}}, 0, '0);
    add_row(OP_MUL, {4{CMIN}}, {4{CMAX}}, 0, '0);
    add_row(OP_MUL, {4{32'hFFFF_FFFF}}, mk_quat(3, '1, 7, -5), 0, '0);
    // rotate: identity, real part of b ignored, conjugate of the minimum,
    // saturated intermediate, small negatives
    add_row(OP_ROT, mk_quat(ONE, 0, 0, 0), mk_quat(1234, 5, -6, 7), 1, mk_quat(0, 5, -6, 7));
    add_row(OP_ROT, mk_quat(ONE, 0, 0, 0), mk_quat(CMAX, ONE, 0, 0), 1, mk_quat(0, ONE, 0, 0));
    add_row(OP_ROT, mk_quat(46341, 0, 0, 46341), mk_quat(CMIN, ONE, 0, 0), 0, '0);
    add_row(OP_ROT, mk_quat(0, ONE, 0, 0), mk_quat(CMAX, ONE, 2 * ONE, 3 * ONE), 0, '0);
    add_row(OP_ROT, mk_quat(0, CMIN, 0, 0), mk_quat(0, ONE, 0, 0), 0, '0);
    add_row(OP_ROT, mk_quat(ONE, CMIN, CMIN, CMIN), mk_quat(0, ONE, ONE, ONE), 0, '0);
    add_row(OP_ROT, {4{CMIN}}, {4{CMIN}}, 0, '0);
    add_row(OP_ROT, {4{CMAX}}, {4{CMAX}}, 0, '0);
    add_row(OP_ROT, mk_quat(ONE, CMIN, CMAX, '1), mk_quat('1, CMIN, CMAX, 1), 0, '0);
    add_row(OP_ROT, {4{32'hFFFF_FFFF}}, mk_quat(0, -3, 9, '1), 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      idle_gap();
      send_item(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b,
                dir_tab[i].fixed_exp ? dir_tab[i].want
                                     : predict_result(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200 || n == 300) begin
        tx_idle_en = (n == 300);
        rx_idle_en <= (n == 300);
      end
      // receiver stalls long enough for the pipe to back up into the input
      if (n == 100) rx_hold_req <= 1'b1;
      if (n == 330) begin
        s_axis_tvalid_i <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
      op = $urandom_range(1);
      a = rand_quat();
      b = rand_quat();
      idle_gap();
      send_item(op, a, b, predict_result(op, a, b));
    end

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------- receiver ----------------

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req <= 1'b0;
      end else begin
        m_axis_tready_i <= !rx_idle_en || ($urandom_range(99) >= 31);
      end
    end
  end

  // ---------------- result check ----------------

  always @(posedge clk_i) begin : result_check
    quat_t got;
    quat_t want;
    string fname[4];
    fname = '{"r_w", "r_x", "r_y", "r_z"};
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (result_q.size() == 0) begin
        report_err($sformatf("result with nothing pending: %h", got));
      end else begin
        want = result_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i]) begin
            report_err($sformatf("%s got %h want %h", fname[i], got[i], want[i]));
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
